// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of the transform core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define M4VT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define M4VT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/m4vt_pkg.sv -----
// Types and constants of the 4x4 matrix-vector transform core.
`timescale 1ns / 1ps

package m4vt_pkg;

	localparam int unsigned NUM_LANES = 4;
	localparam int unsigned COMP_W    = 32;
	localparam int unsigned COEF_W    = 16;
	localparam int unsigned ROW_W     = NUM_LANES * COEF_W;
	localparam int unsigned PROD_W    = COMP_W + COEF_W;
	localparam int unsigned PAIR_W    = PROD_W + 1;
	localparam int unsigned SUM_W     = PROD_W + 2;
	localparam int unsigned FRAC_SHIFT = 8;
	localparam int unsigned SHIFT_W   = SUM_W - FRAC_SHIFT;

	typedef logic signed [COMP_W-1:0] comp_t;
	typedef comp_t                    vec4_t [NUM_LANES];
	typedef logic [ROW_W-1:0]         row_t;

	// Register indexes of the configuration channel
	typedef enum logic [2:0] {
		REG_ROW0 = 3'd0,
		REG_ROW1 = 3'd1,
		REG_ROW2 = 3'd2,
		REG_ROW3 = 3'd3
	} cfg_reg_t;

	// Identity matrix, 1.0 = 0x0100 on the diagonal
	localparam row_t ROW0_RESET = 64'h0000_0000_0000_0100;
	localparam row_t ROW1_RESET = 64'h0000_0000_0100_0000;
	localparam row_t ROW2_RESET = 64'h0000_0100_0000_0000;
	localparam row_t ROW3_RESET = 64'h0100_0000_0000_0000;

	localparam comp_t SAT_MAX = 32'sh7FFF_FFFF;
	localparam comp_t SAT_MIN = 32'sh8000_0000;

	// Load enables for the data stages behind the input register
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

// ----- rtl/m4vt_if.sv -----
// Channel interfaces of the transform core: vector in, result out, register writes.
`timescale 1ns / 1ps

interface m4vt_vec_if import m4vt_pkg::*; ();
	logic  valid;
	logic  ready;
	comp_t in_x;
	comp_t in_y;
	comp_t in_z;
	comp_t in_w;

	modport source (output valid, in_x, in_y, in_z, in_w, input ready);
	modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

interface m4vt_res_if import m4vt_pkg::*; ();
	logic  valid;
	logic  ready;
	comp_t out_x;
	comp_t out_y;
	comp_t out_z;
	comp_t out_w;
	logic  saturated;

	modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
	modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

interface m4vt_cfg_if import m4vt_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_reg_t index;
	row_t     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/matrix4_vector_transform_core.sv -----
// Top level of the 4x4 matrix-vector transform core.
//
// Channels: vec takes one vector of four signed Q16.16 components per beat;
// res returns one beat per vector with four signed Q16.16 components, each
// row of the matrix dotted with the vector, floored and clipped to 32 bits,
// plus a flag set when any component was clipped. cfg writes one 64-bit
// matrix row per beat (index 0 to 3, four Q8.8 coefficients per row); other
// indexes are dropped. Write rows only while no vector is in flight.
// Pipeline: a vec beat reaches its res beat through the input register,
// product register, pair-sum register and output register.
// Throughput: one vector per cycle while res takes its beats; all sixteen
// multipliers work in parallel in the product stage.
// Reset: valid bits clear and the matrix returns to identity.
// Stall: when res is not taken, each stage holds its beat; empty stages
// behind it still fill, so vec stays ready until every stage is full.
`timescale 1ns / 1ps

module matrix4_vector_transform_core import m4vt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	m4vt_vec_if.sink   vec,
	m4vt_res_if.source res,
	m4vt_cfg_if.sink   cfg
);

	row_t      row_q [NUM_LANES];
	vec4_t     vec_s1;
	logic      v_s1;
	logic      v_s2;
	logic      v_s3;
	logic      v_s4;
	logic      en_s1;
	stage_en_t en;
	comp_t     lane_res [NUM_LANES];
	logic [NUM_LANES-1:0] lane_sat;

	assign cfg.ready = 1'b1;

	// Write matrix rows, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= ROW0_RESET;
			row_q[1] <= ROW1_RESET;
			row_q[2] <= ROW2_RESET;
			row_q[3] <= ROW3_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ROW0: row_q[0] <= cfg.data;
				REG_ROW1: row_q[1] <= cfg.data;
				REG_ROW2: row_q[2] <= cfg.data;
				REG_ROW3: row_q[3] <= cfg.data;
				default: ;
			endcase
		end
	end

	// A stage advances when it is empty or the stage after it advances
	always_comb begin
		en.s4 = !v_s4 || res.ready;
		en.s3 = !v_s3 || en.s4;
		en.s2 = !v_s2 || en.s3;
		en_s1 = !v_s1 || en.s2;
	end

	assign vec.ready = en_s1;

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= vec.valid;
			if (en.s2) v_s2 <= v_s1;
			if (en.s3) v_s3 <= v_s2;
			if (en.s4) v_s4 <= v_s3;
		end
	end

	// Stage 1: capture the vector beat
	always_ff @(posedge clk) begin
		if (en_s1) begin
			vec_s1[0] <= vec.in_x;
			vec_s1[1] <= vec.in_y;
			vec_s1[2] <= vec.in_z;
			vec_s1[3] <= vec.in_w;
		end
	end

	// One dot-product pipeline per matrix row
	for (genvar r = 0; r < NUM_LANES; r++) begin : g_row
		m4vt_dot u_dot (
			.clk  (clk),
			.en   (en),
			.coef (row_q[r]),
			.vec  (vec_s1),
			.res  (lane_res[r]),
			.sat  (lane_sat[r])
		);
	end

	assign res.valid     = v_s4;
	assign res.out_x     = lane_res[0];
	assign res.out_y     = lane_res[1];
	assign res.out_z     = lane_res[2];
	assign res.out_w     = lane_res[3];
	assign res.saturated = |lane_sat;

endmodule

// ----- rtl/m4vt_dot.sv -----
// One matrix row dotted with the vector: multiply, two add levels, floor shift and clip.
`timescale 1ns / 1ps

module m4vt_dot import m4vt_pkg::*; (
	input  logic      clk,
	input  stage_en_t en,
	input  row_t      coef,
	input  vec4_t     vec,
	output comp_t     res,
	output logic      sat
);

	logic signed [COEF_W-1:0] coef_lane [NUM_LANES];
	logic signed [PROD_W-1:0] prod_s2 [NUM_LANES];
	logic signed [PAIR_W-1:0] sum01_s3;
	logic signed [PAIR_W-1:0] sum23_s3;
	logic signed [SUM_W-1:0]  total;
	logic signed [SHIFT_W-1:0] shifted;
	logic                     ovf;
	comp_t                    clip;
	comp_t                    res_s4;
	logic                     sat_s4;

	// Unpack the Q8.8 coefficients of this row
	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			coef_lane[k] = $signed(coef[k*COEF_W +: COEF_W]);
		end
	end

	// Stage 2: four Q24.24 products
	always_ff @(posedge clk) begin
		if (en.s2) begin
			for (int k = 0; k < NUM_LANES; k++) begin
				prod_s2[k] <= PROD_W'(coef_lane[k]) * PROD_W'(vec[k]);
			end
		end
	end

	// Stage 3: pairwise sums
	always_ff @(posedge clk) begin
		if (en.s3) begin
			sum01_s3 <= PAIR_W'(prod_s2[0]) + PAIR_W'(prod_s2[1]);
			sum23_s3 <= PAIR_W'(prod_s2[2]) + PAIR_W'(prod_s2[3]);
		end
	end

	// Final sum, floor back to Q16.16, detect range overflow
	always_comb begin
		total   = SUM_W'(sum01_s3) + SUM_W'(sum23_s3);
		shifted = total[SUM_W-1:FRAC_SHIFT];
		ovf     = !((&shifted[SHIFT_W-1:COMP_W-1]) || !(|shifted[SHIFT_W-1:COMP_W-1]));
		if (!ovf) begin
			clip = shifted[COMP_W-1:0];
		end else if (shifted[SHIFT_W-1]) begin
			clip = SAT_MIN;
		end else begin
			clip = SAT_MAX;
		end
	end

	// Stage 4: output register
	always_ff @(posedge clk) begin
		if (en.s4) begin
			res_s4 <= clip;
			sat_s4 <= ovf;
		end
	end

	assign res = res_s4;
	assign sat = sat_s4;

endmodule

// ----- rtl/m4vt_checker.sv -----
// Port-level checks of the transform core and their binding to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module m4vt_checker import m4vt_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  vec_ready,
	input logic  res_valid,
	input logic  res_ready,
	input comp_t out_x,
	input comp_t out_y,
	input comp_t out_z,
	input comp_t out_w,
	input logic  saturated
);

	logic res_stall;
	logic any_clip;

	assign res_stall = res_valid && !res_ready;
	assign any_clip  = (out_x == SAT_MAX) || (out_x == SAT_MIN) ||
		(out_y == SAT_MAX) || (out_y == SAT_MIN) ||
		(out_z == SAT_MAX) || (out_z == SAT_MIN) ||
		(out_w == SAT_MAX) || (out_w == SAT_MIN);

	// Hold a stalled result beat
	`M4VT_ASSERT_NEXT(a_res_hold, res_stall, res_valid, "result beat dropped while stalled")
	`M4VT_ASSERT_NEXT(a_res_stable, res_stall, $stable(out_x) && $stable(out_w) && $stable(saturated), "stalled result changed")
	// A set flag means some lane sits at a range limit
	`M4VT_ASSERT_NOW(a_sat_lane, res_valid && saturated, any_clip, "flag set with no clipped lane")
	// With the output stage empty the whole pipe advances
	`M4VT_ASSERT_NOW(a_ready_free, !res_valid, vec_ready, "input not ready with empty output stage")

endmodule

bind matrix4_vector_transform_core m4vt_checker u_m4vt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.vec_ready (vec.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.out_x     (res.out_x),
	.out_y     (res.out_y),
	.out_z     (res.out_z),
	.out_w     (res.out_w),
	.saturated (res.saturated)
);
